>>> design/assert_macros.svh
// Assertion macros shared by the lexer RTL.
// Depends on clk and rst_n being visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define MLL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lexer check failed");

// Next-cycle implication, disabled during reset
`define MLL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lexer sequence check failed");

`endif

>>> design/mll_pkg.sv
// Shared types, token kind codes and character class functions for the lexer.
// No dependencies.
`default_nettype none

package mll_pkg;

  localparam int POS_BITS_DEF = 16;
  localparam int QDEPTH       = 4;

  typedef logic [5:0] kind_t;

  localparam kind_t K_NONE         = 6'd0;
  localparam kind_t K_PAREN_OPEN   = 6'd1;
  localparam kind_t K_PAREN_CLOSE  = 6'd2;
  localparam kind_t K_WORD         = 6'd3;
  localparam kind_t K_ANGLE_CLOSE  = 6'd4;
  localparam kind_t K_SQ_OPEN      = 6'd5;
  localparam kind_t K_SQ_CLOSE     = 6'd6;
  localparam kind_t K_CURLY_OPEN   = 6'd7;
  localparam kind_t K_CURLY_CLOSE  = 6'd8;
  localparam kind_t K_NUMBER       = 6'd9;
  localparam kind_t K_HASH_ANGLE   = 6'd10;
  localparam kind_t K_HASH_SQ      = 6'd11;
  localparam kind_t K_HASH_PAREN   = 6'd12;
  localparam kind_t K_NIL          = 6'd13;
  localparam kind_t K_UNDEF        = 6'd14;
  localparam kind_t K_UKN          = 6'd15;
  localparam kind_t K_TRUE         = 6'd16;
  localparam kind_t K_FALSE        = 6'd17;
  localparam kind_t K_ASSIGN       = 6'd18;
  localparam kind_t K_COLON        = 6'd19;
  localparam kind_t K_PERCENT      = 6'd20;
  localparam kind_t K_EQUAL        = 6'd21;
  localparam kind_t K_DOT          = 6'd22;
  localparam kind_t K_BAR          = 6'd23;
  localparam kind_t K_SEMI         = 6'd24;
  localparam kind_t K_STRING       = 6'd25;
  localparam kind_t K_RAW          = 6'd26;
  localparam kind_t K_DOLLAR_DOT   = 6'd27;
  localparam kind_t K_DOLLAR_KV    = 6'd28;
  localparam kind_t K_DOLLAR_SEQ   = 6'd29;
  localparam kind_t K_DOLLAR_CURLY = 6'd30;
  localparam kind_t K_DOLLAR_SQ    = 6'd31;
  localparam kind_t K_SYM_STRING   = 6'd32;
  localparam kind_t K_SYM_IDENT    = 6'd33;
  localparam kind_t K_AT_DOT       = 6'd34;
  localparam kind_t K_AT_KV        = 6'd35;
  localparam kind_t K_AT_SEQ       = 6'd36;
  localparam kind_t K_AT_CURLY     = 6'd37;
  localparam kind_t K_AT_SQ        = 6'd38;
  localparam kind_t K_SYM_VAR      = 6'd39;
  localparam kind_t K_BANG_WORD    = 6'd40;
  localparam kind_t K_CARET_WORD   = 6'd41;
  localparam kind_t K_SLASH        = 6'd42;
  localparam kind_t K_COMMENT      = 6'd43;

  // Keyword table selectors
  localparam logic [1:0] KW_NIL   = 2'd0;
  localparam logic [1:0] KW_UNDEF = 2'd1;
  localparam logic [1:0] KW_UKN   = 2'd2;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_BTK = 8'h60;

  // One queued input item
  typedef struct packed {
    logic [7:0] text_byte;
    logic       eot;
  } item_t;

  // One result item
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  cbyte;
    logic        cvalid;
    logic [1:0]  part;
    logic        mneg;
    logic        eneg;
    logic        tend;
    logic [15:0] row;
    logic [15:0] col;
    logic        err;
    logic        last;
  } res_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_id_prefix(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c == "_");
  endfunction

  // Characters that end a word; the zero byte ends everything
  function automatic logic is_word_stop(input logic [7:0] c);
    logic r;
    case (c) inside
      CH_NUL, "=", ":", "%", ".", "/", "|", "!", "#", "$", "@", "<", ">",
      "[", "]", "(", ")", "{", "}", ";": r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_num_stop(input logic [7:0] c);
    logic r;
    case (c) inside
      CH_NUL, ":", "%", "|", "!", "[", "]", "(", ")", "{", "}", "<", ">",
      ";": r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Fixed keyword text, character idx of keyword k
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] idx);
    logic [63:0] s;
    logic [5:0]  base;
    case (k)
      KW_UNDEF: s = {"#undef;", 8'h00};
      KW_UKN:   s = {"#ukn;", 24'h0};
      default:  s = {"#nil;", 24'h0};
    endcase
    base = 6'd63 - {idx, 3'b000};
    return s[base -: 8];
  endfunction

endpackage

`default_nettype wire

>>> design/mll_front.sv
// Front end: input handshake and a short item queue toward the lexer engine.
// Depends on mll_pkg.
`default_nettype none

module mll_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_text_byte,
  input  logic           in_end_of_text,
  output logic           q_valid,
  output mll_pkg::item_t q_item,
  input  logic           q_pop
);
  import mll_pkg::*;

  localparam int AW = $clog2(QDEPTH);
  typedef logic [AW:0] cnt_t;

  item_t         mem_r [QDEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  cnt_t          cnt_r;
  logic          push;
  logic          pop;

  assign in_ready = (cnt_r != cnt_t'(QDEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_item   = mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  // Item storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{text_byte: in_text_byte, eot: in_end_of_text};
    end
  end

  // Pointers wrap naturally, depth is a power of two
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> design/mll_engine.sv
// Back end: lookahead window, lexer modes and result sequencing.
// Depends on mll_pkg. Emits at most one result per cycle.
`default_nettype none

module mll_engine #(
  parameter int POSITION_BITS = mll_pkg::POS_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  mll_pkg::item_t q_item,
  output logic           q_pop,
  input  logic           can_push,
  output logic           push_v,
  output mll_pkg::res_t  push_res
);
  import mll_pkg::*;

  typedef logic [POSITION_BITS-1:0] pos_t;
  localparam pos_t POS_MAX = '1;
  localparam pos_t POS_ONE = pos_t'(1);

  typedef enum logic [3:0] {
    M_IDLE, M_IDFIRST, M_IDENT, M_STRING, M_RAW, M_COMMENT, M_NUMBER, M_SKIP
  } mode_t;

  typedef enum logic {S_LOAD, S_RUN} state_t;

  typedef enum logic [4:0] {
    A_NONE, A_TAKE, A_FIXED, A_KW, A_NUM, A_IDENT, A_QUOTE, A_PREFIX, A_SYMSTR,
    A_COMMENT, A_ERR, A_CONTENT, A_FIRST, A_CLOSE, A_QCLOSE, A_NUMBYTE,
    A_SKIPBYTE, A_FIXCONT, A_FINISH
  } act_t;

  state_t     state_r, state_nxt;
  logic [7:0] win_r [3];
  logic [7:0] win_nxt [3];
  logic [1:0] fill_r, fill_nxt;
  mode_t      mode_r, mode_nxt;
  kind_t      kind_r, kind_nxt;
  logic [2:0] skip_r, skip_nxt;
  pos_t       row_r, row_nxt, col_r, col_nxt;
  pos_t       srow_r, srow_nxt, scol_r, scol_nxt;
  logic [3:0] nfl_r, nfl_nxt;
  logic       err_r, err_nxt;
  logic       end_r, end_nxt;
  logic       fix_act_r, fix_act_nxt;
  logic [1:0] fix_rem_r, fix_rem_nxt;
  logic       fix_kw_r, fix_kw_nxt;
  logic       hold_v_r, hold_v_nxt;
  res_t       hold_r, hold_nxt;

  function automatic pos_t row_after(input pos_t r, input logic [7:0] c);
    return (c == CH_LF && r != POS_MAX) ? r + POS_ONE : r;
  endfunction

  function automatic pos_t col_after(input pos_t k, input logic [7:0] c);
    pos_t v;
    if (c == CH_LF)         v = POS_ONE;
    else if (k != POS_MAX)  v = k + POS_ONE;
    else                    v = k;
    return v;
  endfunction

  function automatic logic [15:0] to16(input pos_t p);
    logic [POSITION_BITS+15:0] w;
    w = {16'h0, p};
    return w[15:0];
  endfunction

  always_comb begin
    logic [7:0] c0, c1, c2;
    logic       soft1, loop_go, dsign, is_e;
    pos_t       row1, col1, row2, col2;
    act_t       act;
    kind_t      a_kind;
    logic [1:0] a_rem;
    logic [2:0] a_skip;
    mode_t      a_mode;
    logic [1:0] take_n;
    logic [1:0] beg;
    logic       emit;
    logic [7:0] rb;
    logic       rcv, rmn, ren, rend, rnone;
    logic [1:0] rpart;
    logic [1:0] kwk, ns;
    logic [2:0] kwlen;

    state_nxt   = state_r;
    win_nxt     = win_r;
    fill_nxt    = fill_r;
    mode_nxt    = mode_r;
    kind_nxt    = kind_r;
    skip_nxt    = skip_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    srow_nxt    = srow_r;
    scol_nxt    = scol_r;
    nfl_nxt     = nfl_r;
    err_nxt     = err_r;
    end_nxt     = end_r;
    fix_act_nxt = fix_act_r;
    fix_rem_nxt = fix_rem_r;
    fix_kw_nxt  = fix_kw_r;
    hold_v_nxt  = hold_v_r;
    hold_nxt    = hold_r;
    q_pop       = 1'b0;
    push_v      = 1'b0;
    push_res    = hold_r;

    act    = A_NONE;
    a_kind = K_NONE;
    a_rem  = 2'd0;
    a_skip = 3'd0;
    a_mode = M_IDLE;
    take_n = 2'd0;
    beg    = 2'd0;
    emit   = 1'b0;
    rb     = 8'h00;
    rcv    = 1'b0;
    rmn    = 1'b0;
    ren    = 1'b0;
    rend   = 1'b0;
    rnone  = 1'b0;
    rpart  = 2'd0;
    is_e   = 1'b0;
    ns     = 2'd0;

    // Window view; bytes beyond the fill count are absent
    c0    = win_r[0];
    c1    = (fill_r > 2'd1) ? win_r[1] : CH_NUL;
    c2    = (fill_r > 2'd2) ? win_r[2] : CH_NUL;
    soft1 = (fill_r <= 2'd1) || is_space(c1);
    dsign = (c0 == "$");
    row1  = row_after(row_r, c0);
    col1  = col_after(col_r, c0);
    row2  = row_after(row1, c1);
    col2  = col_after(col1, c1);
    loop_go = !err_r && (fill_r != 2'd0) && (fill_r == 2'd3 || end_r);

    kwk   = (kind_r == K_UNDEF) ? KW_UNDEF : ((kind_r == K_UKN) ? KW_UKN : KW_NIL);
    kwlen = (kwk == KW_UNDEF) ? 3'd7 : 3'd5;

    // Classify the next step
    unique case (state_r)
      S_LOAD: begin
        if (q_valid) begin
          if (err_r) begin
            q_pop = 1'b1;
          end else begin
            win_nxt[fill_r] = q_item.text_byte;
            fill_nxt        = fill_r + 2'd1;
            end_nxt         = q_item.eot;
            state_nxt       = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (can_push) begin
          if (fix_act_r) begin
            act = A_FIXCONT;
          end else if (loop_go) begin
            unique case (mode_r)
              M_IDFIRST: act = (c0 == CH_NUL) ? A_ERR : A_FIRST;
              M_IDENT:   act = (is_space(c0) || is_word_stop(c0)) ? A_CLOSE : A_CONTENT;
              M_STRING, M_RAW: begin
                if (c0 == ((mode_r == M_STRING) ? "\"" : "'")) act = A_QCLOSE;
                else if (c0 == CH_NUL)                         act = A_ERR;
                else                                           act = A_CONTENT;
              end
              M_COMMENT: begin
                if (c0 == CH_LF)       act = A_CLOSE;
                else if (c0 == CH_NUL) act = A_ERR;
                else                   act = A_CONTENT;
              end
              M_NUMBER:  act = (is_space(c0) || is_num_stop(c0)) ? A_CLOSE : A_NUMBYTE;
              M_SKIP:    act = (c0 == CH_NUL) ? A_ERR : A_SKIPBYTE;
              M_IDLE: begin
                // Token dispatcher
                if (is_space(c0)) begin
                  act = A_TAKE;
                end else begin
                  unique case (c0) inside
                    "(": begin act = A_FIXED; a_kind = K_PAREN_OPEN; end
                    ")": begin act = A_FIXED; a_kind = K_PAREN_CLOSE; end
                    "[": begin act = A_FIXED; a_kind = K_SQ_OPEN; end
                    "]": begin act = A_FIXED; a_kind = K_SQ_CLOSE; end
                    "{": begin act = A_FIXED; a_kind = K_CURLY_OPEN; end
                    "}": begin act = A_FIXED; a_kind = K_CURLY_CLOSE; end
                    "%": begin act = A_FIXED; a_kind = K_PERCENT; end
                    "=": begin act = A_FIXED; a_kind = K_EQUAL; end
                    ".": begin act = A_FIXED; a_kind = K_DOT; end
                    "|": begin act = A_FIXED; a_kind = K_BAR; end
                    ";": begin act = A_FIXED; a_kind = K_SEMI; end
                    "*": begin act = A_FIXED; a_kind = K_WORD; end
                    "<", ">": begin
                      if (c1 == "=") begin
                        act = A_FIXED; a_kind = K_WORD; a_rem = 2'd1;
                      end else if (soft1 || is_word_stop(c1)) begin
                        act = A_FIXED; a_kind = (c0 == "<") ? K_WORD : K_ANGLE_CLOSE;
                      end else begin
                        act = A_ERR;
                      end
                    end
                    "-": begin
                      if (soft1)               begin act = A_FIXED; a_kind = K_WORD; end
                      else if (is_digit(c1))   act = A_NUM;
                      else                     begin act = A_IDENT; a_kind = K_WORD; end
                    end
                    "+": begin
                      if (soft1)               begin act = A_FIXED; a_kind = K_WORD; end
                      else if (is_digit(c1))   act = A_NUM;
                      else                     act = A_ERR;
                    end
                    "#": begin
                      if (c1 == "<") begin
                        act = A_FIXED; a_kind = K_HASH_ANGLE; a_rem = 2'd1;
                      end else if (c1 == "[") begin
                        act = A_FIXED; a_kind = K_HASH_SQ; a_rem = 2'd1;
                      end else if (c1 == "(") begin
                        act = A_FIXED; a_kind = K_HASH_PAREN; a_rem = 2'd1;
                      end else if (c1 == "n" && c2 == "i") begin
                        act = A_KW; a_kind = K_NIL; a_skip = 3'd2;
                      end else if (c1 == "u" && c2 == "n") begin
                        act = A_KW; a_kind = K_UNDEF; a_skip = 3'd4;
                      end else if (c1 == "u" && c2 == "k") begin
                        act = A_KW; a_kind = K_UKN; a_skip = 3'd2;
                      end else if (c1 == "t" && c2 == ";") begin
                        act = A_FIXED; a_kind = K_TRUE; a_rem = 2'd2;
                      end else if (c1 == "f" && c2 == ";") begin
                        act = A_FIXED; a_kind = K_FALSE; a_rem = 2'd2;
                      end else begin
                        act = A_ERR;
                      end
                    end
                    ":": begin
                      act = A_FIXED;
                      if (c1 == "=") begin a_kind = K_ASSIGN; a_rem = 2'd1; end
                      else           a_kind = K_COLON;
                    end
                    "\"": begin act = A_QUOTE; a_kind = K_STRING; a_mode = M_STRING; end
                    "'":  begin act = A_QUOTE; a_kind = K_RAW; a_mode = M_RAW; end
                    "$", "@": begin
                      if (c1 == ".") begin
                        act = A_FIXED; a_rem = 2'd1;
                        a_kind = dsign ? K_DOLLAR_DOT : K_AT_DOT;
                      end else if (c1 == "%" && c2 == ".") begin
                        act = A_FIXED; a_rem = 2'd2;
                        a_kind = dsign ? K_DOLLAR_KV : K_AT_KV;
                      end else if (c1 == "~" && c2 == ".") begin
                        act = A_FIXED; a_rem = 2'd2;
                        a_kind = dsign ? K_DOLLAR_SEQ : K_AT_SEQ;
                      end else if (c1 == "{") begin
                        act = A_FIXED; a_kind = dsign ? K_DOLLAR_CURLY : K_AT_CURLY;
                      end else if (c1 == "[") begin
                        act = A_FIXED; a_kind = dsign ? K_DOLLAR_SQ : K_AT_SQ;
                      end else if (dsign && c1 == "'") begin
                        act = A_SYMSTR;
                      end else begin
                        act = A_PREFIX; a_kind = dsign ? K_SYM_IDENT : K_SYM_VAR;
                      end
                    end
                    "!": begin act = A_PREFIX; a_kind = K_BANG_WORD; end
                    "^": begin act = A_PREFIX; a_kind = K_CARET_WORD; end
                    CH_BTK: act = (c1 == CH_BTK) ? A_COMMENT : A_TAKE;
                    "/": begin act = A_FIXED; a_kind = soft1 ? K_WORD : K_SLASH; end
                    default: begin
                      if (is_digit(c0))          act = A_NUM;
                      else if (is_id_prefix(c0)) begin act = A_IDENT; a_kind = K_WORD; end
                      else                       act = A_ERR;
                    end
                  endcase
                end
              end
              default: mode_nxt = M_IDLE;
            endcase
          end else if (end_r && !err_r && mode_r != M_IDLE) begin
            act = A_CLOSE;
          end else begin
            act = A_FINISH;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase

    // Carry out the step
    case (act)
      A_TAKE: take_n = 2'd1;
      A_FIXED, A_KW: begin
        beg = 2'd1; kind_nxt = a_kind;
        emit = 1'b1; rb = c0; rcv = 1'b1; take_n = 2'd1;
        fix_act_nxt = 1'b1;
        fix_rem_nxt = (act == A_KW) ? 2'd2 : a_rem;
        fix_kw_nxt  = (act == A_KW);
        if (act == A_KW) skip_nxt = a_skip;
      end
      A_NUM: begin
        beg = 2'd1; kind_nxt = K_NUMBER; take_n = 2'd1;
        nfl_nxt = {1'b0, (c0 == "-"), 2'b01};
        emit = 1'b1; rb = c0; rcv = 1'b1;
        rpart = (c0 == "-" || c0 == "+") ? 2'd0 : 2'd1;
        rmn = (c0 == "-");
        mode_nxt = M_NUMBER;
      end
      A_IDENT: begin
        beg = 2'd1; kind_nxt = a_kind; take_n = 2'd1;
        emit = 1'b1; rb = c0; rcv = 1'b1;
        mode_nxt = M_IDENT;
      end
      A_QUOTE: begin
        beg = 2'd1; kind_nxt = a_kind; take_n = 2'd1; mode_nxt = a_mode;
      end
      A_PREFIX: begin
        beg = 2'd2; kind_nxt = a_kind; take_n = 2'd1; mode_nxt = M_IDFIRST;
      end
      A_SYMSTR: begin
        beg = 2'd2; kind_nxt = K_SYM_STRING; take_n = 2'd2; mode_nxt = M_RAW;
      end
      A_COMMENT: begin
        beg = 2'd1; kind_nxt = K_COMMENT; take_n = 2'd2; mode_nxt = M_COMMENT;
      end
      A_ERR: begin
        err_nxt = 1'b1; srow_nxt = row_r; scol_nxt = col_r;
        emit = 1'b1; rnone = 1'b1;
      end
      A_CONTENT, A_FIRST: begin
        emit = 1'b1; rb = c0; rcv = 1'b1; take_n = 2'd1;
        if (act == A_FIRST) mode_nxt = M_IDENT;
      end
      A_CLOSE, A_QCLOSE: begin
        if (act == A_QCLOSE) take_n = 2'd1;
        emit = 1'b1; rend = 1'b1;
        if (kind_r == K_NUMBER) begin rmn = nfl_r[2]; ren = nfl_r[3]; end
        mode_nxt = M_IDLE; fix_act_nxt = 1'b0;
      end
      A_NUMBYTE: begin
        take_n = 2'd1;
        is_e = (c0 == "e" || c0 == "E");
        ns = nfl_r[1:0];
        if (ns == 2'd1 && c0 != "." && !is_e)  rpart = 2'd1;
        else if (ns == 2'd2 && !is_e)           rpart = 2'd2;
        else if (ns == 2'd3 && c0 == "-")       begin nfl_nxt[3] = 1'b1; rpart = 2'd0; end
        else if (ns == 2'd3)                    rpart = 2'd3;
        else                                    rpart = 2'd0;
        if (c0 == ".")  ns = 2'd2;
        else if (is_e)  ns = 2'd3;
        nfl_nxt[1:0] = ns;
        emit = 1'b1; rb = c0; rcv = 1'b1;
        rmn = nfl_nxt[2]; ren = nfl_nxt[3];
      end
      A_SKIPBYTE: begin
        take_n = 2'd1;
        emit = 1'b1; rcv = 1'b1;
        rb = kw_char(kwk, kwlen - skip_r);
        if (skip_r != 3'd0) skip_nxt = skip_r - 3'd1;
        if (skip_nxt == 3'd0) begin
          fix_act_nxt = 1'b1; fix_rem_nxt = 2'd0; fix_kw_nxt = 1'b0;
        end
      end
      A_FIXCONT: begin
        emit = 1'b1;
        if (fix_rem_r != 2'd0) begin
          rb = c0; rcv = 1'b1; take_n = 2'd1;
          fix_rem_nxt = fix_rem_r - 2'd1;
          if (fix_rem_r == 2'd1 && fix_kw_r) begin
            fix_act_nxt = 1'b0; mode_nxt = M_SKIP;
          end
        end else begin
          rend = 1'b1; fix_act_nxt = 1'b0; mode_nxt = M_IDLE;
          if (kind_r == K_NUMBER) begin rmn = nfl_r[2]; ren = nfl_r[3]; end
        end
      end
      A_FINISH: begin
        // End of text without an error resets position and mode for the next text
        if (end_r && !err_r) begin
          win_nxt[0] = CH_NUL; win_nxt[1] = CH_NUL; win_nxt[2] = CH_NUL;
          fill_nxt = 2'd0; mode_nxt = M_IDLE; kind_nxt = K_NONE; skip_nxt = 3'd0;
          row_nxt = POS_ONE; col_nxt = POS_ONE; srow_nxt = POS_ONE; scol_nxt = POS_ONE;
          nfl_nxt = 4'b0001;
        end
        if (hold_v_r) begin
          push_v = 1'b1; push_res.last = 1'b1;
        end
        hold_v_nxt = 1'b0;
        end_nxt = 1'b0;
        q_pop = 1'b1;
        state_nxt = S_LOAD;
      end
      default: ;
    endcase

    // Consume window bytes and advance position
    if (take_n == 2'd1) begin
      win_nxt[0] = win_r[1]; win_nxt[1] = win_r[2]; win_nxt[2] = CH_NUL;
      row_nxt = row1; col_nxt = col1;
      fill_nxt = (fill_r != 2'd0) ? fill_r - 2'd1 : 2'd0;
    end else if (take_n == 2'd2) begin
      win_nxt[0] = win_r[2]; win_nxt[1] = CH_NUL; win_nxt[2] = CH_NUL;
      row_nxt = row2; col_nxt = col2;
      fill_nxt = (fill_r > 2'd1) ? fill_r - 2'd2 : 2'd0;
    end

    // Token start position
    if (beg == 2'd1) begin
      srow_nxt = row_r; scol_nxt = col_r;
    end else if (beg == 2'd2) begin
      srow_nxt = row1; scol_nxt = col1;
    end

    // New result goes to the hold stage; the previous one leaves as not-last
    if (emit) begin
      if (hold_v_r) begin
        push_v = 1'b1; push_res.last = 1'b0;
      end
      hold_v_nxt     = 1'b1;
      hold_nxt.kind  = rnone ? K_NONE : kind_nxt;
      hold_nxt.cbyte = rb;
      hold_nxt.cvalid = rcv;
      hold_nxt.part  = rpart;
      hold_nxt.mneg  = rmn;
      hold_nxt.eneg  = ren;
      hold_nxt.tend  = rend;
      hold_nxt.row   = to16(srow_nxt);
      hold_nxt.col   = to16(scol_nxt);
      hold_nxt.err   = err_nxt;
      hold_nxt.last  = 1'b0;
    end
  end

  // Held result payload
  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
  end

  // Lexer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      win_r[0]  <= CH_NUL;
      win_r[1]  <= CH_NUL;
      win_r[2]  <= CH_NUL;
      fill_r    <= 2'd0;
      mode_r    <= M_IDLE;
      kind_r    <= K_NONE;
      skip_r    <= 3'd0;
      row_r     <= POS_ONE;
      col_r     <= POS_ONE;
      srow_r    <= POS_ONE;
      scol_r    <= POS_ONE;
      nfl_r     <= 4'b0001;
      err_r     <= 1'b0;
      end_r     <= 1'b0;
      fix_act_r <= 1'b0;
      fix_rem_r <= 2'd0;
      fix_kw_r  <= 1'b0;
      hold_v_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      win_r     <= win_nxt;
      fill_r    <= fill_nxt;
      mode_r    <= mode_nxt;
      kind_r    <= kind_nxt;
      skip_r    <= skip_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      srow_r    <= srow_nxt;
      scol_r    <= scol_nxt;
      nfl_r     <= nfl_nxt;
      err_r     <= err_nxt;
      end_r     <= end_nxt;
      fix_act_r <= fix_act_nxt;
      fix_rem_r <= fix_rem_nxt;
      fix_kw_r  <= fix_kw_nxt;
      hold_v_r  <= hold_v_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/markup_language_lexer.sv
// Streaming lexer for a bracket-and-keyword markup language. Text bytes enter
// through a four-item input queue; the engine loads one byte from the queue,
// takes its window steps (one result, a skipped byte or a mode change each),
// then closes the byte's work and pops the byte before it loads the next one.
// Window steps wait while the output register is full and not being read.
// Results leave through an output register, and the last result of each byte
// carries out_last_result.
// Depends on mll_pkg, mll_front, mll_engine and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module markup_language_lexer #(
  parameter int POSITION_BITS = mll_pkg::POS_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_token_kind,
  output logic [7:0]  out_content_byte,
  output logic        out_content_valid,
  output logic [1:0]  out_number_part,
  output logic        out_mantissa_negative,
  output logic        out_exponent_negative,
  output logic        out_token_end,
  output logic [15:0] out_start_row,
  output logic [15:0] out_start_col,
  output logic        out_lex_error,
  output logic        out_last_result
);
  import mll_pkg::*;

  item_t q_item;
  logic  q_valid;
  logic  q_pop;
  logic  can_push;
  logic  push_v;
  res_t  push_res;
  logic  out_valid_r;
  res_t  out_res_r;

  mll_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  mll_engine #(.POSITION_BITS(POSITION_BITS)) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .can_push (can_push),
    .push_v   (push_v),
    .push_res (push_res)
  );

  // Output register
  assign can_push = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (push_v) out_res_r <= push_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push_v) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_token_kind        = out_res_r.kind;
  assign out_content_byte      = out_res_r.cbyte;
  assign out_content_valid     = out_res_r.cvalid;
  assign out_number_part       = out_res_r.part;
  assign out_mantissa_negative = out_res_r.mneg;
  assign out_exponent_negative = out_res_r.eneg;
  assign out_token_end         = out_res_r.tend;
  assign out_start_row         = out_res_r.row;
  assign out_start_col         = out_res_r.col;
  assign out_lex_error         = out_res_r.err;
  assign out_last_result       = out_res_r.last;

  // Checks
  `MLL_ASSERT_IMP(a_content_xor_end, out_valid, !(out_content_valid && out_token_end))
  `MLL_ASSERT_IMP(a_sign_only_num, out_valid && out_token_kind != K_NUMBER, !out_mantissa_negative && !out_exponent_negative)
  `MLL_ASSERT_NXT(a_error_sticky, out_valid && out_ready && out_lex_error, !out_valid || out_lex_error)

endmodule

`default_nettype wire
